[rtl/sacr_pkg.sv]
// Shared constants, types and arithmetic helpers for the sensor average and report core.
package sacr_pkg;

    // Averaging window and field widths
    localparam int AVG_SAMPLES = 8;
    localparam int CNT_W       = $clog2(AVG_SAMPLES + 1);
    localparam int CELSIUS_W   = 16;
    localparam int TEMP_W      = 17;
    localparam int HUM_W       = 15;
    localparam int TIME_W      = 32;
    localparam int DELTA_W     = 16;
    localparam int SUM_W       = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_DELTA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_DELTA  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD     = 2'd2;

    localparam logic [DELTA_W-1:0] TEMP_DELTA_RESET = 16'd256;
    localparam logic [DELTA_W-1:0] HUM_DELTA_RESET  = 16'd512;
    localparam logic [TIME_W-1:0]  PERIOD_RESET     = 32'd300000;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Fahrenheit: floor((18c + 5 + 655360) / 10) - 57344, divide by reciprocal
    localparam int FAHR_NUM_W  = 21;
    localparam int FAHR_BIAS   = 655365;
    localparam int FAHR_RECIP  = 1677722;
    localparam int FAHR_SHIFT  = 24;
    localparam int FAHR_OFFSET = 57344;
    localparam int FAHR_PROD_W = 2 * FAHR_NUM_W;

    // Average: magnitude / AVG_SAMPLES by reciprocal, exact for 24-bit magnitudes
    localparam int     DIV_SHIFT  = 30;
    localparam int     DIV_MULT_W = 30;
    localparam longint DIV_MULT   =
        ((longint'(1) << DIV_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int     DIV_PROD_W = SUM_W + DIV_MULT_W;

    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] value;
    } temp_avg_t;

    typedef struct packed {
        logic              valid;
        logic [HUM_W-1:0]  value;
    } hum_avg_t;

    typedef struct packed {
        logic [DELTA_W-1:0] temp_delta;
        logic [DELTA_W-1:0] hum_delta;
        logic [TIME_W-1:0]  period;
    } report_cfg_t;

    // Celsius Q8.8 to Fahrenheit Q9.8, rounded half up, saturated to 17 bits
    function automatic logic signed [TEMP_W-1:0] fahrenheit(
        input logic signed [CELSIUS_W-1:0] c
    );
        logic signed [FAHR_NUM_W:0]   cx;
        logic signed [FAHR_NUM_W:0]   t;
        logic [FAHR_PROD_W-1:0]       prod;
        logic [TEMP_W:0]              q;
        logic signed [TEMP_W:0]       f;
        cx   = (FAHR_NUM_W + 1)'(c);
        t    = (cx <<< 4) + (cx <<< 1) + (FAHR_NUM_W + 1)'(FAHR_BIAS);
        prod = FAHR_PROD_W'(t[FAHR_NUM_W-1:0]) * FAHR_PROD_W'(FAHR_RECIP);
        q    = prod[FAHR_SHIFT +: TEMP_W + 1];
        f    = $signed(q) - (TEMP_W + 1)'(FAHR_OFFSET);
        if (f > (TEMP_W + 1)'(65535))
            return TEMP_W'(65535);
        else if (f < -(TEMP_W + 1)'(65536))
            return -TEMP_W'(65536);
        return f[TEMP_W-1:0];
    endfunction

    // Unsigned magnitude divided by AVG_SAMPLES, truncated
    function automatic logic [SUM_W-1:0] div_avg(input logic [SUM_W-1:0] mag);
        logic [DIV_PROD_W-1:0] prod;
        prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_MULT);
        return prod[DIV_SHIFT +: SUM_W];
    endfunction

endpackage

[rtl/sacr_item_if.sv]
// Input item channel: opcode, samples and report time.
interface sacr_item_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    opcode;
    logic                                    temp_valid;
    logic signed [sacr_pkg::CELSIUS_W-1:0]   temp_celsius;
    logic                                    hum_valid;
    logic [sacr_pkg::HUM_W-1:0]              humidity;
    logic [sacr_pkg::TIME_W-1:0]             now_ms;

    modport source (
        output valid, opcode, temp_valid, temp_celsius, hum_valid, humidity, now_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, temp_valid, temp_celsius, hum_valid, humidity, now_ms,
        output ready
    );
endinterface

[rtl/sacr_result_if.sv]
// Result item channel: reported averages.
interface sacr_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sacr_pkg::TEMP_W-1:0]   report_temp;
    logic [sacr_pkg::HUM_W-1:0]           report_hum;

    modport source (
        output valid, report_temp, report_hum,
        input  ready
    );
    modport sink (
        input  valid, report_temp, report_hum,
        output ready
    );
endinterface

[rtl/sacr_cfg_if.sv]
// Configuration write channel: register index and data.
interface sacr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [sacr_pkg::CFG_INDEX_W-1:0]     index;
    logic [sacr_pkg::CFG_DATA_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/sacr_temp_chan.sv]
// Temperature channel: Fahrenheit conversion and moving average state.
module sacr_temp_chan (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic signed [sacr_pkg::CELSIUS_W-1:0] celsius,
    output sacr_pkg::temp_avg_t                   avg
);

    logic signed [sacr_pkg::SUM_W-1:0]   sum_reg;
    logic [sacr_pkg::CNT_W-1:0]          count_reg;
    logic signed [sacr_pkg::TEMP_W-1:0]  avg_reg;
    logic                                avg_valid_reg;

    logic signed [sacr_pkg::TEMP_W-1:0]  sample;
    logic [sacr_pkg::SUM_W-1:0]          mag;
    logic [sacr_pkg::SUM_W-1:0]          q;
    logic signed [sacr_pkg::SUM_W:0]     quo;
    logic                                full;
    logic signed [sacr_pkg::SUM_W:0]     sub;
    logic signed [sacr_pkg::SUM_W+1:0]   acc;
    logic signed [sacr_pkg::SUM_W-1:0]   sum_next;
    logic signed [sacr_pkg::TEMP_W-1:0]  avg_next;

    always_comb
    begin
        sample = sacr_pkg::fahrenheit(celsius);
        mag    = sum_reg[sacr_pkg::SUM_W-1] ? sacr_pkg::SUM_W'(-sum_reg)
                                            : sacr_pkg::SUM_W'(sum_reg);
        q      = sacr_pkg::div_avg(mag);
        // truncate toward zero: divide the magnitude, restore the sign
        quo    = sum_reg[sacr_pkg::SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        full   = count_reg >= sacr_pkg::CNT_W'(sacr_pkg::AVG_SAMPLES);
        sub    = full ? quo : '0;
        acc    = (sacr_pkg::SUM_W + 2)'(sum_reg) - (sacr_pkg::SUM_W + 2)'(sub)
               + (sacr_pkg::SUM_W + 2)'(sample);

        if (acc > (sacr_pkg::SUM_W + 2)'(8388607))
            sum_next = sacr_pkg::SUM_W'(8388607);
        else if (acc < -(sacr_pkg::SUM_W + 2)'(8388608))
            sum_next = -sacr_pkg::SUM_W'(8388608);
        else
            sum_next = acc[sacr_pkg::SUM_W-1:0];

        if (quo > (sacr_pkg::SUM_W + 1)'(65535))
            avg_next = sacr_pkg::TEMP_W'(65535);
        else if (quo < -(sacr_pkg::SUM_W + 1)'(65536))
            avg_next = -sacr_pkg::TEMP_W'(65536);
        else
            avg_next = quo[sacr_pkg::TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (count_reg == '0)
            begin
                // seed with the first sample
                sum_reg   <= sacr_pkg::SUM_W'(sample);
                count_reg <= sacr_pkg::CNT_W'(1);
            end
            else
            begin
                sum_reg <= sum_next;
                if (full)
                begin
                    avg_reg       <= avg_next;
                    avg_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + sacr_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign avg.valid = avg_valid_reg;
    assign avg.value = avg_reg;

endmodule

[rtl/sacr_hum_chan.sv]
// Humidity channel: moving average state.
module sacr_hum_chan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [sacr_pkg::HUM_W-1:0]    sample,
    output sacr_pkg::hum_avg_t            avg
);

    logic [sacr_pkg::SUM_W-1:0]   sum_reg;
    logic [sacr_pkg::CNT_W-1:0]   count_reg;
    logic [sacr_pkg::HUM_W-1:0]   avg_reg;
    logic                         avg_valid_reg;

    logic [sacr_pkg::SUM_W-1:0]   q;
    logic                         full;
    logic [sacr_pkg::SUM_W-1:0]   sub;
    logic [sacr_pkg::SUM_W:0]     acc;
    logic [sacr_pkg::SUM_W-1:0]   sum_next;
    logic [sacr_pkg::HUM_W-1:0]   avg_next;

    always_comb
    begin
        q    = sacr_pkg::div_avg(sum_reg);
        full = count_reg >= sacr_pkg::CNT_W'(sacr_pkg::AVG_SAMPLES);
        sub  = full ? q : '0;
        // sum - sum/N never goes negative
        acc  = (sacr_pkg::SUM_W + 1)'(sum_reg - sub) + (sacr_pkg::SUM_W + 1)'(sample);

        if (acc[sacr_pkg::SUM_W])
            sum_next = '1;
        else
            sum_next = acc[sacr_pkg::SUM_W-1:0];

        if (q > sacr_pkg::SUM_W'(32767))
            avg_next = '1;
        else
            avg_next = q[sacr_pkg::HUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (count_reg == '0)
            begin
                sum_reg   <= sacr_pkg::SUM_W'(sample);
                count_reg <= sacr_pkg::CNT_W'(1);
            end
            else
            begin
                sum_reg <= sum_next;
                if (full)
                begin
                    avg_reg       <= avg_next;
                    avg_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + sacr_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign avg.valid = avg_valid_reg;
    assign avg.value = avg_reg;

endmodule

[rtl/sacr_report.sv]
// Report decision: change thresholds, period timer and last reported values.
module sacr_report (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [sacr_pkg::TIME_W-1:0]   now_ms,
    input  sacr_pkg::temp_avg_t           temp_avg,
    input  sacr_pkg::hum_avg_t            hum_avg,
    input  sacr_pkg::report_cfg_t         cfg,
    output logic                          fire
);

    logic signed [sacr_pkg::TEMP_W-1:0]  last_temp_reg;
    logic [sacr_pkg::HUM_W-1:0]          last_hum_reg;
    logic [sacr_pkg::TIME_W-1:0]         last_time_reg;
    logic                                reported_once_reg;

    logic signed [sacr_pkg::TEMP_W:0]    tdiff;
    logic [sacr_pkg::TEMP_W-1:0]         tmag;
    logic signed [sacr_pkg::HUM_W:0]     hdiff;
    logic [sacr_pkg::HUM_W-1:0]          hmag;
    logic [sacr_pkg::TIME_W-1:0]         elapsed;
    logic                                due;

    always_comb
    begin
        tdiff   = (sacr_pkg::TEMP_W + 1)'(temp_avg.value)
                - (sacr_pkg::TEMP_W + 1)'(last_temp_reg);
        tmag    = tdiff[sacr_pkg::TEMP_W] ? sacr_pkg::TEMP_W'(-tdiff)
                                          : tdiff[sacr_pkg::TEMP_W-1:0];
        hdiff   = $signed({1'b0, hum_avg.value}) - $signed({1'b0, last_hum_reg});
        hmag    = hdiff[sacr_pkg::HUM_W] ? sacr_pkg::HUM_W'(-hdiff)
                                         : hdiff[sacr_pkg::HUM_W-1:0];
        // wrapping time difference
        elapsed = now_ms - last_time_reg;
        due     = !reported_once_reg
               || tmag >= sacr_pkg::TEMP_W'(cfg.temp_delta)
               || sacr_pkg::DELTA_W'(hmag) >= cfg.hum_delta
               || elapsed > cfg.period;
        fire    = en && temp_avg.valid && hum_avg.valid && due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg     <= '0;
            last_hum_reg      <= '0;
            last_time_reg     <= '0;
            reported_once_reg <= 1'b0;
        end
        else if (fire)
        begin
            last_temp_reg     <= temp_avg.value;
            last_hum_reg      <= hum_avg.value;
            last_time_reg     <= now_ms;
            reported_once_reg <= 1'b1;
        end
    end

endmodule

[rtl/sensor_average_and_change_report_core.sv]
// Top level: input register, channel averages, report decision and result register.
//
// Averages a temperature channel (Celsius Q8.8 in, Fahrenheit Q9.8 kept) and a
// humidity channel over a window of AVG_SAMPLES and reports both averages on a
// report item, once both are valid, when a change threshold is met, the period
// has run out, or nothing was reported yet. One item is taken every clock cycle
// unless the input register is held by a stalled result; a report is loaded
// into the result register when its item leaves the input register. Each item
// waits in the input register, then a single stage holding the Fahrenheit
// reciprocal multiplier and the two divide-by-window shifts updates the state
// and loads the result register. A stalled result holds the pipe only when the
// result register is full. Configuration writes are taken every cycle and must
// be made while the block is idle.
module sensor_average_and_change_report_core (
    input  logic                 clk,
    input  logic                 rst_n,
    sacr_item_if.sink            item,
    sacr_result_if.source        result,
    sacr_cfg_if.sink             cfg
);

    // Input register
    logic                                  s1_valid_reg;
    logic                                  op_reg;
    logic                                  temp_valid_reg;
    logic signed [sacr_pkg::CELSIUS_W-1:0] celsius_reg;
    logic                                  hum_valid_reg;
    logic [sacr_pkg::HUM_W-1:0]            humidity_reg;
    logic [sacr_pkg::TIME_W-1:0]           now_reg;

    // Result register
    logic                                  out_valid_reg;
    logic signed [sacr_pkg::TEMP_W-1:0]    out_temp_reg;
    logic [sacr_pkg::HUM_W-1:0]            out_hum_reg;

    sacr_pkg::report_cfg_t                 cfg_reg;

    logic                                  advance;
    logic                                  fire;
    sacr_pkg::temp_avg_t                   temp_avg;
    sacr_pkg::hum_avg_t                    hum_avg;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg         <= item.opcode;
            temp_valid_reg <= item.temp_valid;
            celsius_reg    <= item.temp_celsius;
            hum_valid_reg  <= item.hum_valid;
            humidity_reg   <= item.humidity;
            now_reg        <= item.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_delta <= sacr_pkg::TEMP_DELTA_RESET;
            cfg_reg.hum_delta  <= sacr_pkg::HUM_DELTA_RESET;
            cfg_reg.period     <= sacr_pkg::PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sacr_pkg::REG_TEMP_DELTA: cfg_reg.temp_delta <= cfg.data[sacr_pkg::DELTA_W-1:0];
                sacr_pkg::REG_HUM_DELTA:  cfg_reg.hum_delta  <= cfg.data[sacr_pkg::DELTA_W-1:0];
                sacr_pkg::REG_PERIOD:     cfg_reg.period     <= cfg.data[sacr_pkg::TIME_W-1:0];
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    sacr_temp_chan u_temp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance && op_reg == sacr_pkg::OP_SAMPLE && temp_valid_reg),
        .celsius (celsius_reg),
        .avg     (temp_avg)
    );

    sacr_hum_chan u_hum (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance && op_reg == sacr_pkg::OP_SAMPLE && hum_valid_reg),
        .sample (humidity_reg),
        .avg    (hum_avg)
    );

    sacr_report u_report (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance && op_reg == sacr_pkg::OP_REPORT),
        .now_ms   (now_reg),
        .temp_avg (temp_avg),
        .hum_avg  (hum_avg),
        .cfg      (cfg_reg),
        .fire     (fire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_temp_reg <= temp_avg.value;
            out_hum_reg  <= hum_avg.value;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.report_temp = out_temp_reg;
    assign result.report_hum  = out_hum_reg;

`ifndef SYNTHESIS
    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without an item leaving the input register");

    a_report_needs_averages: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> advance && temp_avg.valid && hum_avg.valid)
        else $error("report fired without both averages valid");

    a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result.valid && result.report_temp == $past(temp_avg.value)
                 && result.report_hum == $past(hum_avg.value))
        else $error("report not loaded into the result register");
`endif

endmodule
